[rtl/core/sslcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslcd_pkg
// Shared types, constants and table functions of the seven-segment LCD
// frame builder: glyph ROM, segment scatter map, memory power-on image.
// ----------------------------------------------------------------------------
package sslcd_pkg;

    localparam int SEG_BYTES   = 20;
    localparam int ADDR_W      = 5;
    localparam int DIGITS      = 10;
    localparam int VAL_DIGITS  = 5;
    localparam int SEGS        = 7;

    localparam logic [4:0] GLYPH_BLANK = 5'd17;
    localparam logic [4:0] GLYPH_LAST  = 5'd17;
    localparam logic [3:0] DIGIT_LAST  = 4'd9;
    localparam logic [2:0] STEP_LAST   = 3'd4;

    typedef enum logic [1:0] {
        CMD_SHOW  = 2'd0,
        CMD_DIGIT = 2'd1,
        CMD_RAW   = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIGITS,
        ST_PASS
    } state_t;

    typedef logic [SEGS-1:0] glyph_t;
    typedef logic [DIGITS-1:0][SEGS-1:0] glyph_bank_t;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [2:0] idx;
    } dig_ctl_t;

    typedef struct packed {
        logic [7:0] mask;
        logic [7:0] bits;
    } byte_upd_t;

    // segment a..g of each digit as byte*8+bit
    localparam logic [7:0] SEG_MAP [DIGITS][SEGS] = '{
        '{8'(16*8+1), 8'(11*8+1), 8'(6*8+1),  8'(1*8+1),  8'(6*8+0),  8'(16*8+0), 8'(11*8+0)},
        '{8'(16*8+3), 8'(11*8+3), 8'(6*8+3),  8'(1*8+3),  8'(6*8+2),  8'(16*8+2), 8'(11*8+2)},
        '{8'(16*8+5), 8'(11*8+5), 8'(6*8+5),  8'(1*8+5),  8'(6*8+4),  8'(16*8+4), 8'(11*8+4)},
        '{8'(16*8+7), 8'(11*8+7), 8'(6*8+7),  8'(1*8+7),  8'(6*8+6),  8'(16*8+6), 8'(11*8+6)},
        '{8'(17*8+1), 8'(12*8+1), 8'(7*8+1),  8'(2*8+1),  8'(7*8+0),  8'(17*8+0), 8'(12*8+0)},
        '{8'(0*8+1),  8'(5*8+1),  8'(10*8+1), 8'(15*8+1), 8'(15*8+0), 8'(5*8+0),  8'(10*8+0)},
        '{8'(0*8+3),  8'(5*8+3),  8'(10*8+3), 8'(15*8+3), 8'(15*8+2), 8'(5*8+2),  8'(10*8+2)},
        '{8'(0*8+5),  8'(5*8+5),  8'(10*8+5), 8'(15*8+5), 8'(15*8+4), 8'(5*8+4),  8'(10*8+4)},
        '{8'(0*8+7),  8'(5*8+7),  8'(10*8+7), 8'(15*8+7), 8'(15*8+6), 8'(5*8+6),  8'(10*8+6)},
        '{8'(2*8+2),  8'(7*8+2),  8'(12*8+2), 8'(17*8+2), 8'(17*8+3), 8'(7*8+3),  8'(12*8+3)}
    };

    function automatic glyph_t glyph_pattern(input logic [4:0] code);
        glyph_t p;
        case (code)
            5'd0:    p = 7'h3F;
            5'd1:    p = 7'h06;
            5'd2:    p = 7'h5B;
            5'd3:    p = 7'h4F;
            5'd4:    p = 7'h66;
            5'd5:    p = 7'h6D;
            5'd6:    p = 7'h7D;
            5'd7:    p = 7'h07;
            5'd8:    p = 7'h7F;
            5'd9:    p = 7'h6F;
            5'd10:   p = 7'h77;
            5'd11:   p = 7'h7C;
            5'd12:   p = 7'h39;
            5'd13:   p = 7'h5E;
            5'd14:   p = 7'h79;
            5'd15:   p = 7'h71;
            5'd16:   p = 7'h40;
            default: p = 7'h00;
        endcase
        return p;
    endfunction

    function automatic logic [13:0] digit_divisor(input logic [2:0] idx);
        logic [13:0] d;
        case (idx)
            3'd0:    d = 14'd10000;
            3'd1:    d = 14'd1000;
            3'd2:    d = 14'd100;
            3'd3:    d = 14'd10;
            default: d = 14'd1;
        endcase
        return d;
    endfunction

    function automatic logic [7:0] reset_byte(input logic [ADDR_W-1:0] addr);
        logic [7:0] b;
        case (addr)
            5'd0, 5'd1: b = 8'h11;
            5'd2:       b = 8'h09;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic byte_upd_t byte_update(input logic [ADDR_W-1:0] addr,
                                              input glyph_bank_t glyphs,
                                              input logic [DIGITS-1:0] en);
        byte_upd_t  u;
        logic [7:0] pos;
        u   = '0;
        pos = '0;
        for (int d = 0; d < DIGITS; d++) begin
            for (int s = 0; s < SEGS; s++) begin
                pos = SEG_MAP[d][s];
                if (pos[7:3] == addr && en[d]) begin
                    u.mask[pos[2:0]] = 1'b1;
                    u.bits[pos[2:0]] = glyphs[d][s];
                end
            end
        end
        return u;
    endfunction

endpackage

[rtl/core/seven_segment_lcd_frame_builder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_lcd_frame_builder
// Segment memory for a ten-digit multiplexed LCD. Show splits two values
// into digits, scatters the glyph bits into the memory and streams all
// twenty bytes; set-digit and raw-write only update the memory.
//
//   channel | direction | words per command        | payload
//   s_      | in        | one                      | cmd, values, digit, glyph, raw
//   m_      | out       | twenty on show, else none| seg_address, seg_data, frame_last
//
// Show: after accept, a digit phase (one decimal place per cycle), then a
// read-modify-write pass over the segment RAM, one byte per cycle unless an
// output stall holds it. Set digit: the same pass without output. Raw write:
// done in the accept cycle. Output stalls hold the pass at the RAM read stage.
// Reset: per-byte valid flags make unwritten bytes read as the power-on
// image; no clearing pass.
// ----------------------------------------------------------------------------
module seven_segment_lcd_frame_builder import sslcd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [16:0] s_temperature_value,
    input  logic [16:0] s_humidity_value,
    input  logic [3:0]  s_digit_index,
    input  logic [4:0]  s_glyph_code,
    input  logic [4:0]  s_raw_index,
    input  logic [7:0]  s_raw_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_seg_address,
    output logic [7:0]  m_seg_data,
    output logic        m_frame_last
);

    localparam logic [ADDR_W-1:0] ADDR_END  = ADDR_W'(SEG_BYTES);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(SEG_BYTES - 1);

    state_t                state_reg, state_next;
    logic [2:0]            step_reg, step_next;
    logic [DIGITS-1:0]     en_reg, en_next;
    glyph_bank_t           glyph_reg, glyph_next;
    logic                  send_reg, send_next;
    logic [ADDR_W-1:0]     rd_cnt_reg, rd_cnt_next;
    logic                  s1_valid_reg, s1_valid_next;
    logic [ADDR_W-1:0]     s1_addr_reg, s1_addr_next;
    logic                  s1_init_reg, s1_init_next;
    logic [SEG_BYTES-1:0]  written_reg, written_next;
    logic                  m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]     m_addr_reg, m_addr_next;
    logic [7:0]            m_data_reg, m_data_next;
    logic                  m_last_reg, m_last_next;

    dig_ctl_t              dig_ctl;
    glyph_t                pat_t, pat_h;

    logic                  ram_we, ram_re;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [7:0]            ram_wdata, ram_rdata;

    logic                  accept, s1_adv, issue;
    logic [7:0]            old_byte, new_byte;
    byte_upd_t             upd;

    sslcd_digit_unit u_dig_t (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (dig_ctl),
        .value   (s_temperature_value),
        .pattern (pat_t)
    );

    sslcd_digit_unit u_dig_h (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (dig_ctl),
        .value   (s_humidity_value),
        .pattern (pat_h)
    );

    sslcd_ram #(
        .WIDTH (8),
        .DEPTH (SEG_BYTES)
    ) u_seg_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_cnt_reg),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign old_byte = s1_init_reg ? reset_byte(s1_addr_reg) : ram_rdata;
    assign upd      = byte_update(s1_addr_reg, glyph_reg, en_reg);
    assign new_byte = (old_byte & ~upd.mask) | (upd.bits & upd.mask);

    assign s1_adv = (state_reg == ST_PASS) && s1_valid_reg &&
                    (!send_reg || !m_valid_reg || m_ready);
    assign issue  = (state_reg == ST_PASS) && (rd_cnt_reg != ADDR_END) &&
                    (!s1_valid_reg || s1_adv);

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        en_next       = en_reg;
        glyph_next    = glyph_reg;
        send_next     = send_reg;
        rd_cnt_next   = rd_cnt_reg;
        s1_valid_next = s1_valid_reg;
        s1_addr_next  = s1_addr_reg;
        s1_init_next  = s1_init_reg;
        written_next  = written_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_addr_next   = m_addr_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        dig_ctl       = '0;
        ram_we        = 1'b0;
        ram_waddr     = s_raw_index;
        ram_wdata     = s_raw_value;
        ram_re        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (cmd_t'(s_cmd))
                        CMD_SHOW: begin
                            dig_ctl.load = 1'b1;
                            step_next    = '0;
                            en_next      = '1;
                            send_next    = 1'b1;
                            state_next   = ST_DIGITS;
                        end
                        CMD_DIGIT: begin
                            if (s_digit_index <= DIGIT_LAST && s_glyph_code <= GLYPH_LAST) begin
                                en_next                   = DIGITS'(1) << s_digit_index;
                                glyph_next[s_digit_index] = glyph_pattern(s_glyph_code);
                                send_next                 = 1'b0;
                                rd_cnt_next               = '0;
                                state_next                = ST_PASS;
                            end
                        end
                        CMD_RAW: begin
                            if (s_raw_index < ADDR_END) begin
                                ram_we                    = 1'b1;
                                written_next[s_raw_index] = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIGITS: begin
                dig_ctl.step                       = 1'b1;
                dig_ctl.idx                        = step_reg;
                glyph_next[step_reg]               = pat_t;
                glyph_next[4'(step_reg) + 4'(VAL_DIGITS)] = pat_h;
                step_next                          = step_reg + 3'd1;
                if (step_reg == STEP_LAST) begin
                    rd_cnt_next = '0;
                    state_next  = ST_PASS;
                end
            end
            ST_PASS: begin
                if (s1_adv) begin
                    ram_we                    = 1'b1;
                    ram_waddr                 = s1_addr_reg;
                    ram_wdata                 = new_byte;
                    written_next[s1_addr_reg] = 1'b1;
                    s1_valid_next             = 1'b0;
                    if (send_reg) begin
                        m_valid_next = 1'b1;
                        m_addr_next  = s1_addr_reg;
                        m_data_next  = new_byte;
                        m_last_next  = (s1_addr_reg == ADDR_LAST);
                    end
                end
                if (issue) begin
                    ram_re        = 1'b1;
                    s1_valid_next = 1'b1;
                    s1_addr_next  = rd_cnt_reg;
                    s1_init_next  = !written_reg[rd_cnt_reg];
                    rd_cnt_next   = rd_cnt_reg + 5'd1;
                end
                if (rd_cnt_reg == ADDR_END && (!s1_valid_reg || s1_adv)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            send_reg     <= 1'b0;
            rd_cnt_reg   <= '0;
            s1_valid_reg <= 1'b0;
            written_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            send_reg     <= send_next;
            rd_cnt_reg   <= rd_cnt_next;
            s1_valid_reg <= s1_valid_next;
            written_reg  <= written_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        en_reg      <= en_next;
        glyph_reg   <= glyph_next;
        s1_addr_reg <= s1_addr_next;
        s1_init_reg <= s1_init_next;
        m_addr_reg  <= m_addr_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_seg_address = m_addr_reg;
    assign m_seg_data    = m_data_reg;
    assign m_frame_last  = m_last_reg;

endmodule

[rtl/core/sslcd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sslcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 20
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/sslcd_digit_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslcd_digit_unit
// Splits a value into decimal digits, most significant first, one digit per
// step (4-bit restoring divide by the place value), with leading-zero blank.
// ----------------------------------------------------------------------------
module sslcd_digit_unit import sslcd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  dig_ctl_t    ctl,
    input  logic [16:0] value,
    output glyph_t      pattern
);

    logic [16:0] rem_reg;
    logic [16:0] rem_next;
    logic        seen_reg;
    logic [3:0]  q;
    logic [4:0]  code;

    always_comb begin
        logic [17:0] r;
        logic [17:0] t;
        r = {1'b0, rem_reg};
        t = '0;
        q = '0;
        for (int b = 3; b >= 0; b--) begin
            t = 18'({4'b0, digit_divisor(ctl.idx)} << b);
            if (r >= t) begin
                r    = r - t;
                q[b] = 1'b1;
            end
        end
        rem_next = r[16:0];
        code     = (q == 4'd0 && !seen_reg) ? GLYPH_BLANK : {1'b0, q};
        pattern  = glyph_pattern(code);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            rem_reg <= value;
        end else if (ctl.step) begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (ctl.load) begin
            seen_reg <= 1'b0;
        end else if (ctl.step && q != 4'd0) begin
            seen_reg <= 1'b1;
        end
    end

endmodule

[rtl/core/sslcd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslcd_checker
// Port-level checks of the frame builder: frame byte order, frame end,
// input held off mid-frame, output hold under stall.
// ----------------------------------------------------------------------------
module sslcd_checker import sslcd_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [4:0]  m_seg_address,
    input logic [7:0]  m_seg_data,
    input logic        m_frame_last
);

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(SEG_BYTES - 1);

    logic [ADDR_W-1:0] exp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_reg <= '0;
        end else if (m_valid && m_ready) begin
            exp_reg <= m_frame_last ? '0 : exp_reg + 5'd1;
        end
    end

    a_addr_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_seg_address == exp_reg)
        else $error("frame byte out of order");

    a_last_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_last == (m_seg_address == ADDR_LAST)))
        else $error("frame_last mismatch");

    a_busy_mid_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_last) |-> !s_ready)
        else $error("input ready during frame");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_seg_address) &&
                                  $stable(m_seg_data) && $stable(m_frame_last))
        else $error("output word changed under stall");

endmodule

bind seven_segment_lcd_frame_builder sslcd_checker u_sslcd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_seg_address (m_seg_address),
    .m_seg_data    (m_seg_data),
    .m_frame_last  (m_frame_last)
);

[sim/seven_segment_lcd_frame_builder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_lcd_frame_builder_tb
// Self-checking bench for the LCD frame builder. A queue of show, set-digit,
// raw-write and unused commands (directed corners, then random) feeds a
// valid/ready driver. A shadow segment image predicts every twenty-word frame,
// and the monitor compares each output word against the oldest prediction,
// across phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module seven_segment_lcd_frame_builder_tb;
    import sslcd_pkg::*;

    typedef enum int {
        PH_STEADY,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } phase_t;

    typedef struct {
        cmd_t        cmd;
        logic [16:0] temp_val;
        logic [16:0] humid_val;
        logic [3:0]  digit;
        logic [4:0]  glyph;
        logic [4:0]  raw_idx;
        logic [7:0]  raw_byte;
        int          gap;
        phase_t      phase;
    } lcd_req_t;

    typedef struct packed {
        logic [4:0] addr;
        logic [7:0] data;
        logic       last;
    } seg_word_t;

    localparam logic [6:0] GLYPH_SHAPES [18] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F,
        7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h40, 7'h00
    };

    // byte*8+bit of segments a..g per digit
    localparam logic [7:0] DIGIT_SEG_POS [10][7] = '{
        '{8'd129, 8'd89,  8'd49,  8'd9,   8'd48,  8'd128, 8'd88},
        '{8'd131, 8'd91,  8'd51,  8'd11,  8'd50,  8'd130, 8'd90},
        '{8'd133, 8'd93,  8'd53,  8'd13,  8'd52,  8'd132, 8'd92},
        '{8'd135, 8'd95,  8'd55,  8'd15,  8'd54,  8'd134, 8'd94},
        '{8'd137, 8'd97,  8'd57,  8'd17,  8'd56,  8'd136, 8'd96},
        '{8'd1,   8'd41,  8'd81,  8'd121, 8'd120, 8'd40,  8'd80},
        '{8'd3,   8'd43,  8'd83,  8'd123, 8'd122, 8'd42,  8'd82},
        '{8'd5,   8'd45,  8'd85,  8'd125, 8'd124, 8'd44,  8'd84},
        '{8'd7,   8'd47,  8'd87,  8'd127, 8'd126, 8'd46,  8'd86},
        '{8'd18,  8'd58,  8'd98,  8'd138, 8'd139, 8'd59,  8'd99}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = 2'd0;
    logic [16:0] s_temperature_value = '0;
    logic [16:0] s_humidity_value = '0;
    logic [3:0]  s_digit_index = '0;
    logic [4:0]  s_glyph_code = '0;
    logic [4:0]  s_raw_index = '0;
    logic [7:0]  s_raw_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [4:0]  m_seg_address;
    logic [7:0]  m_seg_data;
    logic        m_frame_last;

    lcd_req_t  pending_q [$];
    seg_word_t frame_bytes_q [$];
    lcd_req_t  cur;
    logic      have_item = 1'b0;
    int        gap_cnt = 0;
    phase_t    cur_phase = PH_STEADY;
    phase_t    fill_phase = PH_STEADY;
    logic      in_fire = 1'b0;
    int        err_count = 0;
    logic [7:0] lcd_image [SEG_BYTES];

    seven_segment_lcd_frame_builder dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_cmd               (s_cmd),
        .s_temperature_value (s_temperature_value),
        .s_humidity_value    (s_humidity_value),
        .s_digit_index       (s_digit_index),
        .s_glyph_code        (s_glyph_code),
        .s_raw_index         (s_raw_index),
        .s_raw_value         (s_raw_value),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_seg_address       (m_seg_address),
        .m_seg_data          (m_seg_data),
        .m_frame_last        (m_frame_last)
    );

    always #10 aclk = ~aclk;

    function automatic void paint_digit(input logic [3:0] digit, input logic [4:0] code);
        logic [7:0] pos;
        logic [6:0] shape;
        if (digit > DIGIT_LAST || code > GLYPH_LAST) return;
        shape = GLYPH_SHAPES[code];
        for (int s = 0; s < 7; s++) begin
            pos = DIGIT_SEG_POS[digit][s];
            lcd_image[pos[7:3]][pos[2:0]] = shape[s];
        end
    endfunction

    function automatic void paint_value(input logic [16:0] value, input int first);
        int unsigned place [5];
        bit lit;
        place[0] = value / 10000;
        place[1] = (value % 10000) / 1000;
        place[2] = (value % 1000) / 100;
        place[3] = (value % 100) / 10;
        place[4] = value % 10;
        lit = 1'b0;
        for (int i = 0; i < 5; i++) begin
            if (place[i] == 0 && !lit) begin
                paint_digit(4'(first + i), GLYPH_BLANK);
            end else begin
                lit = 1'b1;
                paint_digit(4'(first + i), 5'(place[i]));
            end
        end
    endfunction

    function automatic void apply_cmd(input lcd_req_t r);
        seg_word_t w;
        case (r.cmd)
            CMD_SHOW: begin
                paint_value(r.temp_val, 0);
                paint_value(r.humid_val, 5);
                for (int a = 0; a < SEG_BYTES; a++) begin
                    w.addr = 5'(a);
                    w.data = lcd_image[a];
                    w.last = (a == SEG_BYTES - 1);
                    frame_bytes_q.push_back(w);
                end
            end
            CMD_DIGIT: paint_digit(r.digit, r.glyph);
            CMD_RAW: begin
                if (r.raw_idx < SEG_BYTES) lcd_image[r.raw_idx] = r.raw_byte;
            end
            default: ;
        endcase
    endfunction

    function automatic int send_idle_pct(input phase_t ph);
        case (ph)
            PH_SEND_IDLE: return 66;
            PH_BOTH:      return 25;
            default:      return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input phase_t ph);
        case (ph)
            PH_RECV_STALL: return 66;
            PH_BOTH:       return 25;
            default:       return 0;
        endcase
    endfunction

    task automatic queue_req(input cmd_t cmd, input logic [16:0] tv, input logic [16:0] hv,
                             input logic [3:0] dig, input logic [4:0] gl,
                             input logic [4:0] ri, input logic [7:0] rv);
        lcd_req_t r;
        r.cmd       = cmd;
        r.temp_val  = tv;
        r.humid_val = hv;
        r.digit     = dig;
        r.glyph     = gl;
        r.raw_idx   = ri;
        r.raw_byte  = rv;
        r.phase     = fill_phase;
        r.gap       = 0;
        while (r.gap < 40 && $urandom_range(99) < send_idle_pct(fill_phase)) r.gap++;
        pending_q.push_back(r);
    endtask

    function automatic logic [16:0] rand_value();
        int k;
        if ($urandom_range(9) == 0) return 17'($urandom_range(131071));
        k = $urandom_range(5);
        case (k)
            0:       return 17'd0;
            1:       return 17'($urandom_range(9));
            2:       return 17'($urandom_range(99));
            3:       return 17'($urandom_range(999));
            4:       return 17'($urandom_range(9999));
            default: return 17'($urandom_range(99999));
        endcase
    endfunction

    task automatic check_word(input seg_word_t got);
        seg_word_t want;
        if (frame_bytes_q.size() == 0) begin
            err_count++;
            if (err_count <= 10)
                $display("%0t: unexpected word addr=%0d data=%02h last=%0b",
                         $realtime, got.addr, got.data, got.last);
        end else begin
            want = frame_bytes_q.pop_front();
            if (got.addr !== want.addr || got.data !== want.data || got.last !== want.last) begin
                err_count++;
                if (err_count <= 10)
                    $display("%0t: expected addr=%0d data=%02h last=%0b, got addr=%0d data=%02h last=%0b",
                             $realtime, want.addr, want.data, want.last,
                             got.addr, got.data, got.last);
            end
        end
    endtask

    // driver
    always @(negedge aclk) begin
        logic drive_v;
        drive_v = 1'b0;
        if (aresetn) begin
            if (in_fire) have_item = 1'b0;
            if (!have_item && pending_q.size() != 0) begin
                cur       = pending_q.pop_front();
                have_item = 1'b1;
                gap_cnt   = cur.gap;
                cur_phase = cur.phase;
            end
            if (have_item) begin
                if (gap_cnt > 0) gap_cnt--;
                else drive_v = 1'b1;
                s_cmd               <= cur.cmd;
                s_temperature_value <= cur.temp_val;
                s_humidity_value    <= cur.humid_val;
                s_digit_index       <= cur.digit;
                s_glyph_code        <= cur.glyph;
                s_raw_index         <= cur.raw_idx;
                s_raw_value         <= cur.raw_byte;
            end
        end
        s_valid <= drive_v;
        m_ready <= ($urandom_range(99) >= recv_stall_pct(cur_phase));
    end

    // predictor and monitor
    always @(posedge aclk) begin
        seg_word_t got;
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_valid && s_ready;
            if (s_valid && s_ready) apply_cmd(cur);
            if (m_valid && m_ready) begin
                got.addr = m_seg_address;
                got.data = m_seg_data;
                got.last = m_frame_last;
                check_word(got);
            end
        end
    end

    initial begin
        int   sel;
        cmd_t cmd;
        for (int a = 0; a < SEG_BYTES; a++) lcd_image[a] = 8'h00;
        lcd_image[0] = 8'h11;
        lcd_image[1] = 8'h11;
        lcd_image[2] = 8'h09;

        fill_phase = PH_STEADY;
        queue_req(CMD_SHOW, 17'd0, 17'd0, 4'd0, 5'd0, 5'd0, 8'h00);
        queue_req(CMD_SHOW, 17'd99999, 17'd99999, 4'd15, 5'd31, 5'd31, 8'hFF);
        queue_req(CMD_SHOW, 17'd131071, 17'd100000, 4'd0, 5'd0, 5'd0, 8'h00);
        queue_req(CMD_SHOW, 17'd1, 17'd10, 4'd0, 5'd0, 5'd0, 8'h00);
        queue_req(CMD_SHOW, 17'd12345, 17'd67890, 4'd0, 5'd0, 5'd0, 8'h00);
        queue_req(CMD_SHOW, 17'd120000, 17'd130005, 4'd0, 5'd0, 5'd0, 8'h00);
        queue_req(CMD_DIGIT, 17'd0, 17'd0, 4'd0, 5'd16, 5'd0, 8'h00);
        queue_req(CMD_DIGIT, 17'd0, 17'd0, 4'd9, 5'd15, 5'd0, 8'h00);
        queue_req(CMD_DIGIT, 17'd0, 17'd0, 4'd4, 5'd8, 5'd0, 8'h00);
        queue_req(CMD_DIGIT, 17'd0, 17'd0, 4'd5, 5'd17, 5'd0, 8'h00);
        queue_req(CMD_DIGIT, 17'd0, 17'd0, 4'd10, 5'd3, 5'd0, 8'h00);
        queue_req(CMD_DIGIT, 17'd0, 17'd0, 4'd2, 5'd18, 5'd0, 8'h00);
        queue_req(CMD_DIGIT, 17'd0, 17'd0, 4'd15, 5'd31, 5'd0, 8'h00);
        queue_req(CMD_SHOW, 17'd0, 17'd0, 4'd0, 5'd0, 5'd0, 8'h00);
        queue_req(CMD_RAW, 17'd0, 17'd0, 4'd0, 5'd0, 5'd0, 8'hFF);
        queue_req(CMD_RAW, 17'd0, 17'd0, 4'd0, 5'd0, 5'd19, 8'hA5);
        queue_req(CMD_RAW, 17'd0, 17'd0, 4'd0, 5'd0, 5'd3, 8'hFF);
        queue_req(CMD_RAW, 17'd0, 17'd0, 4'd0, 5'd0, 5'd20, 8'h5A);
        queue_req(CMD_RAW, 17'd0, 17'd0, 4'd0, 5'd0, 5'd31, 8'h5A);
        queue_req(CMD_NONE, 17'd99999, 17'd1, 4'd3, 5'd4, 5'd5, 8'h77);
        queue_req(CMD_SHOW, 17'd0, 17'd0, 4'd0, 5'd0, 5'd0, 8'h00);
        queue_req(CMD_SHOW, 17'd88888, 17'd88888, 4'd0, 5'd0, 5'd0, 8'h00);

        for (int n = 0; n < 320; n++) begin
            fill_phase = phase_t'((n / 40) % 4);
            sel = $urandom_range(99);
            cmd = (sel < 40) ? CMD_SHOW : (sel < 70) ? CMD_DIGIT :
                  (sel < 95) ? CMD_RAW : CMD_NONE;
            queue_req(cmd, rand_value(), rand_value(),
                      ($urandom_range(9) == 0) ? 4'($urandom_range(15, 10))
                                               : 4'($urandom_range(9)),
                      ($urandom_range(9) == 0) ? 5'($urandom_range(31, 18))
                                               : 5'($urandom_range(17)),
                      ($urandom_range(9) == 0) ? 5'($urandom_range(31, 20))
                                               : 5'($urandom_range(19)),
                      8'($urandom_range(255)));
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || have_item) @(posedge aclk);
        while (frame_bytes_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        if (err_count == 0 && frame_bytes_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
